FILE: sv/fbc_pkg.sv
// Shared types and constants for the force/torque bias calibration and EMA filter.
// Used by the interfaces, the controller, the datapath and the top level.
package fbc_pkg;

  localparam int ID_W       = 29;
  localparam int WORD_W     = 16;
  localparam int OUT_W      = 25;
  localparam int GAIN_W     = 16;
  localparam int CNT_W      = 10;
  localparam int KIND_W     = 2;
  localparam int CHAN_W     = 3;
  localparam int NUM_CHAN   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 29;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_FORCE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TORQUE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_COUNT = 2'd3;

  // register reset values
  localparam logic [ID_W-1:0]   RST_FORCE_ID  = 29'd0;
  localparam logic [ID_W-1:0]   RST_TORQUE_ID = 29'd1;
  localparam logic [GAIN_W-1:0] RST_GAIN      = 16'd3932;
  localparam logic [CNT_W-1:0]  RST_CAL_COUNT = 10'd100;

  // channel slots: force x/y/z then torque x/y/z
  localparam logic [CHAN_W-1:0] CHAN_FORCE_X  = 3'd0;
  localparam logic [CHAN_W-1:0] CHAN_FORCE_Z  = 3'd2;
  localparam logic [CHAN_W-1:0] CHAN_TORQUE_X = 3'd3;
  localparam logic [CHAN_W-1:0] CHAN_TORQUE_Z = 3'd5;

  typedef struct packed {
    logic              capture;
    logic              accum;
    logic              div_start;
    logic              set_ready;
    logic              ema_mul;
    logic              ema_upd;
    logic              load_out;
    logic [CHAN_W-1:0] chan;
  } cmd_t;

  typedef struct packed {
    logic cal_due;
    logic torque_grp;
    logic div_done;
    logic run_ok;
  } status_t;

endpackage

FILE: sv/fbc_if.sv
// Valid/ready channel interfaces for input frames and filter results.
// Depends on fbc_pkg for field widths.
interface fbc_in_if;
  logic                      valid;
  logic                      ready;
  logic [fbc_pkg::ID_W-1:0]  frame_id;
  logic [fbc_pkg::WORD_W-1:0] word_x;
  logic [fbc_pkg::WORD_W-1:0] word_y;
  logic [fbc_pkg::WORD_W-1:0] word_z;

  modport source (output valid, frame_id, word_x, word_y, word_z, input ready);
  modport sink (input valid, frame_id, word_x, word_y, word_z, output ready);
endinterface

interface fbc_out_if;
  logic                              valid;
  logic                              ready;
  logic [fbc_pkg::KIND_W-1:0]        frame_kind;
  logic                              filter_running;
  logic signed [fbc_pkg::OUT_W-1:0]  force_out_x;
  logic signed [fbc_pkg::OUT_W-1:0]  force_out_y;
  logic signed [fbc_pkg::OUT_W-1:0]  force_out_z;
  logic signed [fbc_pkg::OUT_W-1:0]  torque_out_x;
  logic signed [fbc_pkg::OUT_W-1:0]  torque_out_y;
  logic signed [fbc_pkg::OUT_W-1:0]  torque_out_z;

  modport source (output valid, frame_kind, filter_running, force_out_x, force_out_y,
                  force_out_z, torque_out_x, torque_out_y, torque_out_z, input ready);
  modport sink (input valid, frame_kind, filter_running, force_out_x, force_out_y,
                force_out_z, torque_out_x, torque_out_y, torque_out_z, output ready);
endinterface

FILE: sv/fbc_div.sv
// Restoring divider, one quotient bit per cycle, used to form the bias means.
// Standalone; no package dependencies.
module fbc_div #(
  parameter int DVD_W = 34,
  parameter int DVS_W = 10,
  parameter int QUO_W = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  assign rem_sh   = {rem, dvd[DVD_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = dvd[QUO_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DVD_W);
        dvd   <= dividend;
        dvs   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        // shift in the next dividend bit, subtract when it fits
        if (fits) begin
          rem <= DVS_W'(rem_sh - {1'b0, dvs});
        end else begin
          rem <= DVS_W'(rem_sh);
        end
        dvd   <= {dvd[DVD_W-2:0], fits};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/fbc_datapath.sv
// Datapath: configuration registers, calibration sums, biases, EMA state and the
// result register. Depends on fbc_pkg and instantiates fbc_div.
module fbc_datapath #(
  parameter int FRAC_BITS       = 8,
  parameter int MAX_CAL_SAMPLES = 1023
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [fbc_pkg::ID_W-1:0]         frame_id,
  input  logic [fbc_pkg::WORD_W-1:0]       word_x,
  input  logic [fbc_pkg::WORD_W-1:0]       word_y,
  input  logic [fbc_pkg::WORD_W-1:0]       word_z,
  input  fbc_pkg::cmd_t                    cmd,
  output fbc_pkg::status_t                 st,
  output logic [fbc_pkg::KIND_W-1:0]       frame_kind,
  output logic                             filter_running,
  output logic signed [fbc_pkg::OUT_W-1:0] filt [fbc_pkg::NUM_CHAN]
);

  localparam int CNT_MAX = (1 << fbc_pkg::CNT_W) - 1;
  localparam int CAP     = (MAX_CAL_SAMPLES < CNT_MAX) ? MAX_CAL_SAMPLES : CNT_MAX;
  localparam int SEEN_W  = $clog2(CAP + 1);
  localparam int SUM_W   = fbc_pkg::WORD_W + SEEN_W;
  localparam int OFS_W   = fbc_pkg::WORD_W + FRAC_BITS;
  localparam int DVD_W   = SUM_W + FRAC_BITS;
  localparam int D_W     = OFS_W + 1;
  localparam int DS_W    = ((D_W > fbc_pkg::OUT_W) ? D_W : fbc_pkg::OUT_W) + 1;
  localparam int PROD_W  = DS_W + fbc_pkg::GAIN_W + 1;
  localparam int NEXT_W  = DS_W + 2;
  localparam int N_CH    = fbc_pkg::NUM_CHAN;
  localparam int SHIFT   = fbc_pkg::GAIN_W;

  localparam logic signed [PROD_W-1:0] RND    = PROD_W'(1) << (SHIFT - 1);
  localparam logic signed [NEXT_W-1:0] SAT_HI = NEXT_W'((1 << (fbc_pkg::OUT_W - 1)) - 1);
  localparam logic signed [NEXT_W-1:0] SAT_LO = -(NEXT_W'(1 << (fbc_pkg::OUT_W - 1)));

  // configuration
  logic [fbc_pkg::ID_W-1:0]   force_id;
  logic [fbc_pkg::ID_W-1:0]   torque_id;
  logic [fbc_pkg::GAIN_W-1:0] gain;
  logic [fbc_pkg::CNT_W-1:0]  cal_count;

  // captured item
  logic [fbc_pkg::KIND_W-1:0] kind;
  logic [fbc_pkg::WORD_W-1:0] word [3];

  // channel state
  logic [SUM_W-1:0]                 sum [N_CH];
  logic [OFS_W-1:0]                 offset [N_CH];
  logic signed [fbc_pkg::OUT_W-1:0] smooth [N_CH];
  logic [fbc_pkg::WORD_W-1:0]       last [N_CH];
  logic [SEEN_W-1:0]                force_seen;
  logic [SEEN_W-1:0]                torque_seen;
  logic                             force_ready;
  logic                             torque_ready;
  logic signed [PROD_W-1:0]         prod;

  logic [fbc_pkg::KIND_W-1:0] kind_next;
  logic [fbc_pkg::CNT_W-1:0]  target;
  logic                       is_torque;
  logic                       grp_ready;
  logic [SEEN_W-1:0]          grp_seen;
  logic [SEEN_W-1:0]          div_seen;
  logic [DVD_W-1:0]           dividend;
  logic                       div_done;
  logic [OFS_W-1:0]           div_quo;
  logic signed [D_W-1:0]      d_val;
  logic signed [DS_W-1:0]     diff;
  logic signed [PROD_W-1:0]   prod_next;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [PROD_W-1:0]   step;
  logic signed [NEXT_W-1:0]   upd;
  logic signed [fbc_pkg::OUT_W-1:0] upd_sat;

  always_comb begin
    if (frame_id == force_id) begin
      kind_next = fbc_pkg::KIND_FORCE;
    end else if (frame_id == torque_id) begin
      kind_next = fbc_pkg::KIND_TORQUE;
    end else begin
      kind_next = fbc_pkg::KIND_IGNORED;
    end
  end

  // zero counts as one sample, large counts clamp at the cap
  always_comb begin
    if (cal_count == '0) begin
      target = fbc_pkg::CNT_W'(1);
    end else if (cal_count > fbc_pkg::CNT_W'(CAP)) begin
      target = fbc_pkg::CNT_W'(CAP);
    end else begin
      target = cal_count;
    end
  end

  assign is_torque = (kind == fbc_pkg::KIND_TORQUE);
  assign grp_ready = is_torque ? torque_ready : force_ready;
  assign grp_seen  = is_torque ? torque_seen : force_seen;

  assign st.cal_due    = (kind != fbc_pkg::KIND_IGNORED) && !grp_ready &&
                         ((fbc_pkg::CNT_W + 1)'(grp_seen) + (fbc_pkg::CNT_W + 1)'(1) >=
                          (fbc_pkg::CNT_W + 1)'(target));
  assign st.torque_grp = is_torque;
  assign st.div_done   = div_done;
  assign st.run_ok     = (kind != fbc_pkg::KIND_IGNORED) && force_ready && torque_ready;

  // rounded mean: (sum << FRAC_BITS + seen/2) / seen
  assign div_seen = (cmd.chan >= fbc_pkg::CHAN_TORQUE_X) ? torque_seen : force_seen;
  assign dividend = (DVD_W'(sum[cmd.chan]) << FRAC_BITS) + DVD_W'(div_seen >> 1);

  fbc_div #(
    .DVD_W(DVD_W),
    .DVS_W(SEEN_W),
    .QUO_W(OFS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (div_seen),
    .done     (div_done),
    .quotient (div_quo)
  );

  // EMA: s += floor((gain * (d - s) + 2^15) / 2^16), then saturate
  assign d_val     = $signed({1'b0, OFS_W'(last[cmd.chan]) << FRAC_BITS}) -
                     $signed({1'b0, offset[cmd.chan]});
  assign diff      = DS_W'(d_val) - DS_W'(smooth[cmd.chan]);
  assign prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, gain}));
  assign rnd       = prod + RND;
  assign step      = rnd >>> SHIFT;
  assign upd       = NEXT_W'(step) + NEXT_W'(smooth[cmd.chan]);

  always_comb begin
    if (upd > SAT_HI) begin
      upd_sat = fbc_pkg::OUT_W'(SAT_HI);
    end else if (upd < SAT_LO) begin
      upd_sat = fbc_pkg::OUT_W'(SAT_LO);
    end else begin
      upd_sat = fbc_pkg::OUT_W'(upd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      force_id     <= fbc_pkg::RST_FORCE_ID;
      torque_id    <= fbc_pkg::RST_TORQUE_ID;
      gain         <= fbc_pkg::RST_GAIN;
      cal_count    <= fbc_pkg::RST_CAL_COUNT;
      kind         <= fbc_pkg::KIND_IGNORED;
      force_seen   <= '0;
      torque_seen  <= '0;
      force_ready  <= 1'b0;
      torque_ready <= 1'b0;
      for (int i = 0; i < N_CH; i++) begin
        sum[i]    <= '0;
        offset[i] <= '0;
        smooth[i] <= '0;
        last[i]   <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          fbc_pkg::REG_FORCE_ID:  force_id  <= cfg_data[fbc_pkg::ID_W-1:0];
          fbc_pkg::REG_TORQUE_ID: torque_id <= cfg_data[fbc_pkg::ID_W-1:0];
          fbc_pkg::REG_GAIN:      gain      <= cfg_data[fbc_pkg::GAIN_W-1:0];
          fbc_pkg::REG_CAL_COUNT: cal_count <= cfg_data[fbc_pkg::CNT_W-1:0];
          default: ;
        endcase
      end

      if (cmd.capture) begin
        kind    <= kind_next;
        word[0] <= word_x;
        word[1] <= word_y;
        word[2] <= word_z;
      end

      if (cmd.accum) begin
        for (int i = 0; i < 3; i++) begin
          if (kind == fbc_pkg::KIND_FORCE) begin
            last[i] <= word[i];
            if (!force_ready) begin
              sum[i] <= sum[i] + SUM_W'(word[i]);
            end
          end else if (kind == fbc_pkg::KIND_TORQUE) begin
            last[i + 3] <= word[i];
            if (!torque_ready) begin
              sum[i + 3] <= sum[i + 3] + SUM_W'(word[i]);
            end
          end
        end
        if (kind == fbc_pkg::KIND_FORCE && !force_ready) begin
          force_seen <= force_seen + SEEN_W'(1);
        end
        if (kind == fbc_pkg::KIND_TORQUE && !torque_ready) begin
          torque_seen <= torque_seen + SEEN_W'(1);
        end
      end

      if (div_done) begin
        offset[cmd.chan] <= div_quo;
      end

      if (cmd.set_ready) begin
        if (is_torque) begin
          torque_ready <= 1'b1;
        end else begin
          force_ready <= 1'b1;
        end
      end

      if (cmd.ema_upd) begin
        smooth[cmd.chan] <= upd_sat;
      end
    end
  end

  // product and result registers carry no reset
  always_ff @(posedge clk) begin
    if (cmd.ema_mul) begin
      prod <= prod_next;
    end
    if (cmd.load_out) begin
      frame_kind     <= kind;
      filter_running <= st.run_ok;
      for (int i = 0; i < N_CH; i++) begin
        filt[i] <= smooth[i];
      end
    end
  end

endmodule

FILE: sv/fbc_ctrl.sv
// Controller: sequences capture, accumulation, bias division and the six EMA
// updates of one item, and owns the result valid. Depends on fbc_pkg.
module fbc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  fbc_pkg::status_t st,
  output fbc_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_DIV_WAIT,
    S_SETRDY,
    S_CHECK,
    S_MUL,
    S_UPD,
    S_OUT
  } state_t;

  state_t                     state;
  logic [fbc_pkg::CHAN_W-1:0] chan;
  logic                       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.chan      = chan;
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.accum     = (state == S_ACC);
    cmd.div_start = (state == S_DIV);
    cmd.set_ready = (state == S_SETRDY);
    cmd.ema_mul   = (state == S_MUL);
    cmd.ema_upd   = (state == S_UPD);
    cmd.load_out  = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chan      <= fbc_pkg::CHAN_FORCE_X;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (st.cal_due) begin
            chan  <= st.torque_grp ? fbc_pkg::CHAN_TORQUE_X : fbc_pkg::CHAN_FORCE_X;
            state <= S_DIV;
          end else begin
            state <= S_CHECK;
          end
        end
        S_DIV: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (st.div_done) begin
            if (chan == fbc_pkg::CHAN_FORCE_Z || chan == fbc_pkg::CHAN_TORQUE_Z) begin
              state <= S_SETRDY;
            end else begin
              chan  <= chan + fbc_pkg::CHAN_W'(1);
              state <= S_DIV;
            end
          end
        end
        S_SETRDY: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          chan <= fbc_pkg::CHAN_FORCE_X;
          if (st.run_ok) begin
            state <= S_MUL;
          end else begin
            state <= S_OUT;
          end
        end
        S_MUL: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (chan == fbc_pkg::CHAN_TORQUE_Z) begin
            state <= S_OUT;
          end else begin
            chan  <= chan + fbc_pkg::CHAN_W'(1);
            state <= S_MUL;
          end
        end
        S_OUT: begin
          // hold until the result register is free
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/ft_bias_calibrate_ema_filter.sv
// Six-channel force/torque bias calibration and EMA filter. CAN frames that are
// ignored or taken while still calibrating skip the EMA updates; once the filter
// runs, one shared multiplier updates the six channels in turn. The frame that
// completes a triple's calibration adds three restoring divisions of one quotient
// bit per cycle and a final step to mark the triple calibrated. A new frame is
// taken while the previous result still waits on the output register. Filter
// outputs are counts with FRAC_BITS fraction bits, saturated to 25 bits signed;
// scaling is left to software.
module ft_bias_calibrate_ema_filter #(
  parameter int FRAC_BITS       = 8,
  parameter int MAX_CAL_SAMPLES = 1023
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbc_pkg::CFG_DATA_W-1:0] cfg_data,
  fbc_in_if.sink                         frames,
  fbc_out_if.source                      results
);

  fbc_pkg::cmd_t    cmd;
  fbc_pkg::status_t st;
  logic signed [fbc_pkg::OUT_W-1:0] filt [fbc_pkg::NUM_CHAN];

  fbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frames.valid),
    .in_ready  (frames.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .st        (st),
    .cmd       (cmd)
  );

  fbc_datapath #(
    .FRAC_BITS      (FRAC_BITS),
    .MAX_CAL_SAMPLES(MAX_CAL_SAMPLES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .frame_id       (frames.frame_id),
    .word_x         (frames.word_x),
    .word_y         (frames.word_y),
    .word_z         (frames.word_z),
    .cmd            (cmd),
    .st             (st),
    .frame_kind     (results.frame_kind),
    .filter_running (results.filter_running),
    .filt           (filt)
  );

  assign results.force_out_x  = filt[0];
  assign results.force_out_y  = filt[1];
  assign results.force_out_z  = filt[2];
  assign results.torque_out_x = filt[3];
  assign results.torque_out_y = filt[4];
  assign results.torque_out_z = filt[5];

  a_run_kind: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.filter_running |->
      results.frame_kind != fbc_pkg::KIND_IGNORED)
    else $error("filter ran on an ignored frame");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    frames.valid && frames.ready |=> !frames.ready)
    else $error("second item taken while one is in work");

  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> !frames.ready && !cmd.load_out)
    else $error("division finished outside calibration");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !results.valid)
    else $error("result valid right after reset");

endmodule

FILE: verif/ft_bias_calibrate_ema_filter_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the force/torque bias calibration and EMA filter.
// Drives CAN frames with random gaps and stalls, predicts every result in place.
// Depends on fbc_pkg, the fbc_in_if/fbc_out_if interfaces and the filter RTL.
module ft_bias_calibrate_ema_filter_test;

  localparam int FRAC = 8;
  localparam logic [fbc_pkg::ID_W-1:0] ID_MAX = {fbc_pkg::ID_W{1'b1}};
  localparam int CAL_MAX = 1023;
  localparam int SIDE_FORCE = 0;
  localparam int SIDE_TORQUE = 1;
  localparam int LONG_HOLD = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [fbc_pkg::ID_W-1:0]   id;
    logic [fbc_pkg::WORD_W-1:0] x;
    logic [fbc_pkg::WORD_W-1:0] y;
    logic [fbc_pkg::WORD_W-1:0] z;
  } frame_t;

  typedef struct {
    logic [fbc_pkg::KIND_W-1:0]       kind;
    logic                             running;
    logic signed [fbc_pkg::OUT_W-1:0] chan[fbc_pkg::NUM_CHAN];
  } filter_result_t;

  localparam string CHAN_NAMES[fbc_pkg::NUM_CHAN] = '{"force_out_x", "force_out_y",
                                                      "force_out_z", "torque_out_x",
                                                      "torque_out_y", "torque_out_z"};

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [fbc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fbc_pkg::CFG_DATA_W-1:0] cfg_data;

  fbc_in_if frames_if();
  fbc_out_if results_if();

  ft_bias_calibrate_ema_filter uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .frames(frames_if),
    .results(results_if)
  );

  // filter model: register copies and state, index 0 force, 1 torque
  logic [fbc_pkg::ID_W-1:0]         force_id_reg = fbc_pkg::RST_FORCE_ID;
  logic [fbc_pkg::ID_W-1:0]         torque_id_reg = fbc_pkg::RST_TORQUE_ID;
  logic [fbc_pkg::GAIN_W-1:0]       gain_reg = fbc_pkg::RST_GAIN;
  logic [fbc_pkg::CNT_W-1:0]        cal_reg = fbc_pkg::RST_CAL_COUNT;
  logic [25:0]                      cal_sum[2][3] = '{default: '0};
  int unsigned                      cal_seen[2] = '{default: 0};
  bit                               cal_done[2] = '{default: 0};
  logic [23:0]                      bias[2][3] = '{default: '0};
  logic signed [fbc_pkg::OUT_W-1:0] smooth[2][3] = '{default: '0};
  logic [fbc_pkg::WORD_W-1:0]       latest[2][3] = '{default: '0};

  frame_t         frame_queue[$];
  filter_result_t pending_results[$];
  filter_result_t predicted;
  frame_t         next_frame;
  logic           frame_taken;

  int frames_queued = 0;
  int frames_taken = 0;
  int results_checked = 0;
  int mismatches = 0;
  int kind_tally[3] = '{default: 0};
  int advanced = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asks = 0;
  int hold_served = 0;

  function automatic void add_sample(int g);
    longint unsigned target;
    longint unsigned scaled;
    if (cal_done[g]) return;
    for (int i = 0; i < 3; i++) cal_sum[g][i] += latest[g][i];
    cal_seen[g]++;
    target = (cal_reg == 0) ? 1 : cal_reg;
    if (cal_seen[g] >= target) begin
      for (int i = 0; i < 3; i++) begin
        scaled = (longint'(cal_sum[g][i]) << FRAC) + cal_seen[g] / 2;
        bias[g][i] = 24'(scaled / cal_seen[g]);
      end
      cal_done[g] = 1'b1;
    end
  endfunction

  function automatic logic signed [fbc_pkg::OUT_W-1:0] ema_next(
      logic signed [fbc_pkg::OUT_W-1:0] s, logic [fbc_pkg::WORD_W-1:0] cnt,
      logic [23:0] off);
    longint d;
    longint acc;
    longint n;
    d = (longint'(cnt) << FRAC) - longint'(off);
    acc = longint'(gain_reg) * (d - longint'(s)) + 32768;
    // arithmetic shift of a signed value floors, which gives round half up
    n = longint'(s) + (acc >>> 16);
    if (n > 16777215) n = 16777215;
    if (n < -16777216) n = -16777216;
    return n[fbc_pkg::OUT_W-1:0];
  endfunction

  function automatic filter_result_t step_filter(frame_t f);
    filter_result_t r;
    int g;
    g = -1;
    r.running = 1'b0;
    if (f.id == force_id_reg) begin
      r.kind = fbc_pkg::KIND_FORCE;
      g = SIDE_FORCE;
    end else if (f.id == torque_id_reg) begin
      r.kind = fbc_pkg::KIND_TORQUE;
      g = SIDE_TORQUE;
    end else begin
      r.kind = fbc_pkg::KIND_IGNORED;
    end
    if (g >= 0) begin
      latest[g][0] = f.x;
      latest[g][1] = f.y;
      latest[g][2] = f.z;
      add_sample(g);
      if (cal_done[SIDE_FORCE] && cal_done[SIDE_TORQUE]) begin
        r.running = 1'b1;
        for (int s = 0; s < 2; s++)
          for (int i = 0; i < 3; i++)
            smooth[s][i] = ema_next(smooth[s][i], latest[s][i], bias[s][i]);
      end
    end
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < 3; i++) r.chan[s * 3 + i] = smooth[s][i];
    return r;
  endfunction

  task automatic check_result();
    filter_result_t want;
    logic signed [fbc_pkg::OUT_W-1:0] got[fbc_pkg::NUM_CHAN];
    if (pending_results.size() == 0) begin
      $error("result item arrived with no frame outstanding");
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    got[0] = results_if.force_out_x;
    got[1] = results_if.force_out_y;
    got[2] = results_if.force_out_z;
    got[3] = results_if.torque_out_x;
    got[4] = results_if.torque_out_y;
    got[5] = results_if.torque_out_z;
    if (results_if.frame_kind !== want.kind) begin
      $error("frame_kind: expected %0d, got %0d", want.kind, results_if.frame_kind);
      mismatches++;
    end
    if (results_if.filter_running !== want.running) begin
      $error("filter_running: expected %0d, got %0d", want.running,
             results_if.filter_running);
      mismatches++;
    end
    for (int i = 0; i < fbc_pkg::NUM_CHAN; i++) begin
      if (got[i] !== want.chan[i]) begin
        $error("%s: expected %0d, got %0d", CHAN_NAMES[i], want.chan[i], got[i]);
        mismatches++;
      end
    end
  endtask

  task automatic write_reg(logic [fbc_pkg::CFG_IDX_W-1:0] idx,
                           logic [fbc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      fbc_pkg::REG_FORCE_ID:  force_id_reg = val[fbc_pkg::ID_W-1:0];
      fbc_pkg::REG_TORQUE_ID: torque_id_reg = val[fbc_pkg::ID_W-1:0];
      fbc_pkg::REG_GAIN:      gain_reg = val[fbc_pkg::GAIN_W-1:0];
      fbc_pkg::REG_CAL_COUNT: cal_reg = val[fbc_pkg::CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_frame(logic [fbc_pkg::ID_W-1:0] id, logic [fbc_pkg::WORD_W-1:0] x,
                             logic [fbc_pkg::WORD_W-1:0] y, logic [fbc_pkg::WORD_W-1:0] z);
    frame_queue.push_back(frame_t'({id, x, y, z}));
    frames_queued++;
  endtask

  // hold until every queued frame is taken and every result has come back
  task automatic wait_idle();
    while (frames_taken != frames_queued || pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [fbc_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return fbc_pkg::WORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [fbc_pkg::ID_W-1:0] pick_other_id();
    logic [fbc_pkg::ID_W-1:0] id;
    // near misses of the force id, otherwise anything
    if ($urandom_range(3) == 0)
      id = force_id_reg ^ (fbc_pkg::ID_W'(1) << $urandom_range(fbc_pkg::ID_W - 1));
    else id = fbc_pkg::ID_W'($urandom);
    while (id == force_id_reg || id == torque_id_reg) id = fbc_pkg::ID_W'($urandom);
    return id;
  endfunction

  task automatic queue_mix(int count, int ignore_pct);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < ignore_pct)
        queue_frame(pick_other_id(), pick_word(), pick_word(), pick_word());
      else if (r < ignore_pct + (100 - ignore_pct) / 2)
        queue_frame(force_id_reg, pick_word(), pick_word(), pick_word());
      else
        queue_frame(torque_id_reg, pick_word(), pick_word(), pick_word());
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // driver: offer the next item once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      frames_if.valid <= 1'b0;
    end else if (!frames_if.valid || frame_taken) begin
      if (send_wait == 0 && $urandom_range(99) < send_idle_pct)
        send_wait = $urandom_range(15, 1);
      if (send_wait > 0 || frame_queue.size() == 0) begin
        frames_if.valid <= 1'b0;
        if (send_wait > 0) send_wait--;
      end else begin
        next_frame = frame_queue.pop_front();
        frames_if.valid <= 1'b1;
        frames_if.frame_id <= next_frame.id;
        frames_if.word_x <= next_frame.x;
        frames_if.word_y <= next_frame.y;
        frames_if.word_z <= next_frame.z;
      end
    end
  end

  // receiver: random stalls, plus a long hold on request
  always @(negedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        recv_wait = LONG_HOLD;
      end else if (recv_wait == 0 && $urandom_range(99) < recv_idle_pct) begin
        recv_wait = $urandom_range(15, 1);
      end
      if (recv_wait > 0) begin
        results_if.ready <= 1'b0;
        recv_wait--;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on each accepted frame, check each accepted result
  always @(posedge clk) begin
    if (rst) begin
      frame_taken <= 1'b0;
    end else begin
      frame_taken <= frames_if.valid && frames_if.ready;
      if (results_if.valid && results_if.ready) check_result();
      if (frames_if.valid && frames_if.ready) begin
        predicted = step_filter(frame_t'({frames_if.frame_id, frames_if.word_x,
                                          frames_if.word_y, frames_if.word_z}));
        pending_results.push_back(predicted);
        kind_tally[predicted.kind]++;
        if (predicted.running) advanced++;
        frames_taken++;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (frames_if.valid && frames_if.ready) || (results_if.valid && results_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int torque_left;
    int r;
    logic [fbc_pkg::ID_W-1:0] fid;
    logic [fbc_pkg::ID_W-1:0] tid;

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    frames_if.valid = 1'b0;
    frames_if.frame_id = '0;
    frames_if.word_x = '0;
    frames_if.word_y = '0;
    frames_if.word_z = '0;
    results_if.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 20;
    recv_idle_pct = 20;
    // reset settings: both triples start calibrating toward 100 samples
    queue_frame(fbc_pkg::RST_FORCE_ID, 16'hFFFF, 16'h0000, 16'h8000);
    queue_frame(fbc_pkg::RST_TORQUE_ID, 16'h0000, 16'hFFFF, 16'h7FFF);
    queue_frame(29'd2, 16'h1234, 16'h5678, 16'h9ABC);
    queue_frame(ID_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_frame(fbc_pkg::RST_FORCE_ID, 16'hFFFF, 16'h0000, 16'h0001);
    wait_idle();

    // zero count acts as one, below the force samples already taken
    write_reg(fbc_pkg::REG_CAL_COUNT, '0);
    queue_frame(fbc_pkg::RST_FORCE_ID, 16'hFFFF, 16'h0000, 16'h0000);
    wait_idle();

    // equal ids: force wins; set bias must not move with the count
    write_reg(fbc_pkg::REG_CAL_COUNT, fbc_pkg::CFG_DATA_W'(CAL_MAX));
    write_reg(fbc_pkg::REG_TORQUE_ID, fbc_pkg::RST_FORCE_ID);
    queue_frame(fbc_pkg::RST_FORCE_ID, 16'h0000, 16'hFFFF, 16'hAAAA);
    queue_frame(fbc_pkg::RST_TORQUE_ID, 16'h5555, 16'hAAAA, 16'h0000);
    wait_idle();

    write_reg(fbc_pkg::REG_FORCE_ID, ID_MAX);
    write_reg(fbc_pkg::REG_GAIN, fbc_pkg::CFG_DATA_W'(16'hFFFF));
    queue_frame(ID_MAX, 16'h0000, 16'h0000, 16'h0000);
    queue_frame(29'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_frame(ID_MAX ^ 29'd1, 16'h0F0F, 16'hF0F0, 16'h00FF);
    wait_idle();

    // torque holds two samples; finish its calibration at the largest count
    send_idle_pct = 15;
    recv_idle_pct = 15;
    torque_left = CAL_MAX - 2;
    while (torque_left > 0) begin
      r = $urandom_range(99);
      if (r < 8) begin
        queue_frame(force_id_reg, pick_word(), pick_word(), pick_word());
      end else if (r < 12) begin
        queue_frame(pick_other_id(), pick_word(), pick_word(), pick_word());
      end else begin
        queue_frame(torque_id_reg, pick_word(), pick_word(), pick_word());
        torque_left--;
      end
    end
    wait_idle();

    send_idle_pct = 25;
    recv_idle_pct = 25;
    queue_mix(120, 10);
    wait_idle();

    // no idling; gain zero freezes the filter, equal ids again
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(fbc_pkg::REG_GAIN, '0);
    write_reg(fbc_pkg::REG_TORQUE_ID, ID_MAX);
    write_reg(fbc_pkg::REG_CAL_COUNT, fbc_pkg::CFG_DATA_W'($urandom_range(CAL_MAX)));
    queue_mix(80, 10);
    wait_idle();

    fid = fbc_pkg::ID_W'($urandom);
    tid = fbc_pkg::ID_W'($urandom);
    if (tid == fid) tid = tid ^ 29'd1;
    write_reg(fbc_pkg::REG_FORCE_ID, fid);
    write_reg(fbc_pkg::REG_TORQUE_ID, tid);
    write_reg(fbc_pkg::REG_GAIN, fbc_pkg::CFG_DATA_W'($urandom_range(16'hFFFF)));
    send_idle_pct = 20;
    recv_idle_pct = 10;
    queue_mix(200, 10);
    // hold the output off while frames keep coming, so the input backs up
    hold_asks++;
    wait_idle();

    write_reg(fbc_pkg::REG_FORCE_ID, fbc_pkg::RST_FORCE_ID);
    write_reg(fbc_pkg::REG_TORQUE_ID, fbc_pkg::RST_TORQUE_ID);
    write_reg(fbc_pkg::REG_GAIN, fbc_pkg::CFG_DATA_W'(fbc_pkg::RST_GAIN));
    send_idle_pct = 30;
    recv_idle_pct = 30;
    queue_mix(150, 10);
    wait_idle();

    write_reg(fbc_pkg::REG_GAIN, fbc_pkg::CFG_DATA_W'($urandom_range(16'hFFFF)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_mix(100, 5);
    wait_idle();

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Checked %0d results from %0d frames: %0d force, %0d torque, %0d ignored.",
             results_checked, frames_taken, kind_tally[fbc_pkg::KIND_FORCE],
             kind_tally[fbc_pkg::KIND_TORQUE], kind_tally[fbc_pkg::KIND_IGNORED]);
    $display("Filter advanced on %0d frames after a full-length torque calibration.",
             advanced);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
